[rtl/tdf_pkg.sv]
`default_nettype none

package tdf_pkg;

  localparam int FACTOR_W      = 32;
  localparam int COUNT_W       = 33;
  localparam int MAX_RESULTS   = 32;
  localparam int KW            = $clog2(MAX_RESULTS);
  localparam int FIRST_DIVISOR = 2;
  localparam int PRIME_EXIT_MIN = 5;

  // controller -> datapath
  typedef struct packed {
    logic load;         // capture a new number
    logic div_start;    // launch remaining / divisor
    logic inc_div;      // divisor + 1
    logic emit_factor;  // push divisor as a factor, remaining <= quotient
    logic emit_last;    // push the final word
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic tiny;      // number below two
    logic div_done;  // quotient and remainder ready
    logic done_loop; // divisor exceeds quotient
    logic rem_zero;  // divisor divides remaining
    logic cap;       // factor slots used up
    logic out_free;  // output register can take a word
  } st_t;

endpackage

`default_nettype wire

[rtl/tdf_divider.sv]
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module tdf_divider #(
  parameter int W = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] dividend_i,
  input  wire logic [W-1:0] divisor_i,
  output logic              done_o,
  output logic [W-1:0]      quotient_o,
  output logic [W-1:0]      remainder_o
);

  localparam int CntW = (W > 1) ? $clog2(W) : 1;

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [W-1:0]    acc_q;
  logic [W-1:0]    quo_q;

  logic [W:0]      trial;
  logic [W:0]      diff;
  logic            fits;

  assign trial = {acc_q, quo_q[W-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign fits  = (trial >= {1'b0, divisor_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      acc_q <= fits ? diff[W-1:0] : trial[W-1:0];
      quo_q <= {quo_q[W-2:0], fits};
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = acc_q;

endmodule

`default_nettype wire

[rtl/tdf_datapath.sv]
`default_nettype none

module tdf_datapath #(
  parameter int NUM_WIDTH = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire tdf_pkg::cmd_t                cmd_i,
  input  wire logic [NUM_WIDTH-1:0]         number_i,
  input  wire logic                         out_stall_i,
  output tdf_pkg::st_t                      st_o,
  output logic                              out_valid_o,
  output logic [tdf_pkg::FACTOR_W-1:0]      factor_o,
  output logic                              is_last_o,
  output logic [tdf_pkg::COUNT_W-1:0]       loop_count_o
);

  localparam int WideW = ((NUM_WIDTH > tdf_pkg::COUNT_W) ? NUM_WIDTH : tdf_pkg::COUNT_W) + 1;

  logic [NUM_WIDTH-1:0]        rem_val_q;
  logic [NUM_WIDTH-1:0]        div_q;
  logic [tdf_pkg::KW-1:0]      k_q;
  logic                        found_q;
  logic                        big_q;
  logic                        tiny_q;

  logic                        out_valid_q;
  logic [tdf_pkg::FACTOR_W-1:0] factor_q;
  logic                        last_q;
  logic [tdf_pkg::COUNT_W-1:0] count_q;

  logic                        div_done;
  logic [NUM_WIDTH-1:0]        quo;
  logic [NUM_WIDTH-1:0]        rmd;

  logic [WideW-1:0]            wide_rem;
  logic [WideW-1:0]            wide_div;
  logic [WideW-1:0]            wide_sum;
  logic [tdf_pkg::COUNT_W-1:0] final_count;

  tdf_divider #(.W(NUM_WIDTH)) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (rem_val_q),
    .divisor_i   (div_q),
    .done_o      (div_done),
    .quotient_o  (quo),
    .remainder_o (rmd)
  );

  // final count: 0 below two, prime exit gives the divisor, else factors + 1 + remaining - 2
  assign wide_rem = WideW'(rem_val_q);
  assign wide_div = WideW'(div_q);
  assign wide_sum = wide_rem + WideW'(k_q) - WideW'(1);

  always_comb begin
    if (tiny_q) begin
      final_count = '0;
    end else if (!found_q && big_q) begin
      final_count = wide_div[tdf_pkg::COUNT_W-1:0];
    end else begin
      final_count = wide_sum[tdf_pkg::COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rem_val_q <= number_i;
      div_q     <= NUM_WIDTH'(tdf_pkg::FIRST_DIVISOR);
      k_q       <= '0;
      found_q   <= 1'b0;
      big_q     <= (number_i >= NUM_WIDTH'(tdf_pkg::PRIME_EXIT_MIN));
      tiny_q    <= (number_i < NUM_WIDTH'(tdf_pkg::FIRST_DIVISOR));
    end else if (cmd_i.inc_div) begin
      div_q <= div_q + NUM_WIDTH'(1);
    end else if (cmd_i.emit_factor) begin
      rem_val_q <= quo;
      k_q       <= k_q + tdf_pkg::KW'(1);
      found_q   <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_factor || cmd_i.emit_last) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_factor) begin
      factor_q <= wide_div[tdf_pkg::FACTOR_W-1:0];
      last_q   <= 1'b0;
      count_q  <= '0;
    end else if (cmd_i.emit_last) begin
      factor_q <= wide_rem[tdf_pkg::FACTOR_W-1:0];
      last_q   <= 1'b1;
      count_q  <= final_count;
    end
  end

  assign st_o.tiny      = tiny_q;
  assign st_o.div_done  = div_done;
  assign st_o.done_loop = (div_q > quo);
  assign st_o.rem_zero  = (rmd == '0);
  assign st_o.cap       = (k_q == tdf_pkg::KW'(tdf_pkg::MAX_RESULTS - 1));
  assign st_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign factor_o     = factor_q;
  assign is_last_o    = last_q;
  assign loop_count_o = count_q;

endmodule

`default_nettype wire

[rtl/tdf_ctrl.sv]
`default_nettype none

module tdf_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire tdf_pkg::st_t  st_i,
  output tdf_pkg::cmd_t      cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_START = 5'b00010,
    S_DIV   = 5'b00100,
    S_EMIT  = 5'b01000,
    S_FINAL = 5'b10000
  } state_e;

  state_e state_q;
  state_e state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_START;
        end
      end
      S_START: begin
        if (st_i.tiny) begin
          state_d = S_FINAL;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        if (st_i.div_done) begin
          if (st_i.done_loop) begin
            state_d = S_FINAL;
          end else if (st_i.rem_zero) begin
            state_d = st_i.cap ? S_FINAL : S_EMIT;
          end else begin
            cmd_o.inc_div = 1'b1;
            state_d       = S_START;
          end
        end
      end
      S_EMIT: begin
        if (st_i.out_free) begin
          cmd_o.emit_factor = 1'b1;
          state_d           = S_START;
        end
      end
      S_FINAL: begin
        if (st_i.out_free) begin
          cmd_o.emit_last = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

[rtl/trial_division_factorizer_unit.sv]
`default_nettype none

// Flow: each trial division runs the bit-serial divider (one quotient bit a cycle), and
//   each factor word takes an emit step; the final word follows the last division
//   (no division is run for a number below two). Output stalls can hold each word.
// Throughput: one number at a time, the next taken in the cycle after the final word is
//   loaded; up to ~65536 divisions for 32-bit inputs. Reset: rst_ni async, active low.
module trial_division_factorizer_unit #(
  parameter int NUM_WIDTH = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // number in
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [NUM_WIDTH-1:0]            number_i,
  // factor words out
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [tdf_pkg::FACTOR_W-1:0]         factor_o,
  output logic                                 is_last_o,
  output logic [tdf_pkg::COUNT_W-1:0]          loop_count_o
);

  tdf_pkg::cmd_t cmd;
  tdf_pkg::st_t  st;

  // Sequencer: divide remaining by divisor, then either exit (divisor above
  // quotient, or factor slots used up), divide out the factor, or bump the divisor.
  tdf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // Working registers, divider and the output register. The output register
  // lets a new number be taken while the last word still waits.
  tdf_datapath #(.NUM_WIDTH(NUM_WIDTH)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .number_i     (number_i),
    .out_stall_i  (out_stall_i),
    .st_o         (st),
    .out_valid_o  (out_valid_o),
    .factor_o     (factor_o),
    .is_last_o    (is_last_o),
    .loop_count_o (loop_count_o)
  );

`ifndef SYNTHESIS
  // a non-final factor word means the number is still being worked on
  a_mid_word_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_last_o |-> in_stall_o)
    else $error("intermediate factor while idle");

  // loop count only on the final word
  a_count_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_last_o |-> loop_count_o == '0)
    else $error("loop count on non-final word");

  // divided-out factors are never below two
  a_factor_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_last_o |-> factor_o >= tdf_pkg::FACTOR_W'(tdf_pkg::FIRST_DIVISOR))
    else $error("factor below two");

  // taking a number makes the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("not busy after accept");
`endif

endmodule

`default_nettype wire
